// ----- rtl/core/two_state_kalman_filter_defines.svh -----
// assertion macros for the two-state kalman filter
`ifndef TWO_STATE_KALMAN_FILTER_DEFINES_SVH
`define TWO_STATE_KALMAN_FILTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TSKF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TSKF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tskf_pkg.sv -----
// types, constants, arithmetic helpers and micro-program for the kalman filter
package tskf_pkg;

    localparam int JOINTS    = 8;
    localparam int FRAC_BITS = 32;

    localparam int VW       = 48;
    localparam int NW       = 47;
    localparam int STEP_W   = 32;
    localparam int JOINT_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W     = 7;
    localparam int SLOT_W   = 5;
    localparam int PROD_W   = 2 * VW;
    localparam int HALF_W   = VW / 2;
    localparam int DIV_W    = VW + FRAC_BITS;
    localparam int DIV_CW   = $clog2(DIV_W + 1);
    localparam int RAM_DEPTH = JOINTS * 8 + 32;

    localparam int DT_SHL = (FRAC_BITS >= STEP_W) ? FRAC_BITS - STEP_W : 0;
    localparam int DT_SHR = (FRAC_BITS < STEP_W) ? STEP_W - FRAC_BITS : 0;

    localparam logic [VW-1:0] VMAX     = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN     = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] ONE_VAL  = VW'(64'd1 << FRAC_BITS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DSTEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MSTEP  = 3'd6;

    localparam logic [NW-1:0]     RST_QP    = 47'd4295;
    localparam logic [NW-1:0]     RST_QV    = 47'd4294967;
    localparam logic [NW-1:0]     RST_RP    = 47'd42950;
    localparam logic [NW-1:0]     RST_RV    = 47'd42949673;
    localparam logic [STEP_W-1:0] RST_DSTEP = 32'd17179869;
    localparam logic [STEP_W-1:0] RST_MSTEP = 32'd429496730;

    // operand slots: below 8 are per-joint state, 8 and up are scratch
    localparam logic [SLOT_W-1:0] S_POS = 5'd0;
    localparam logic [SLOT_W-1:0] S_VEL = 5'd1;
    localparam logic [SLOT_W-1:0] S_PP  = 5'd2;
    localparam logic [SLOT_W-1:0] S_PV  = 5'd3;
    localparam logic [SLOT_W-1:0] S_VP  = 5'd4;
    localparam logic [SLOT_W-1:0] S_VV  = 5'd5;
    localparam logic [SLOT_W-1:0] T_A   = 5'd8;
    localparam logic [SLOT_W-1:0] T_B   = 5'd9;
    localparam logic [SLOT_W-1:0] T_C   = 5'd10;
    localparam logic [SLOT_W-1:0] T_Q   = 5'd11;
    localparam logic [SLOT_W-1:0] T_DT  = 5'd12;
    localparam logic [SLOT_W-1:0] T_X0  = 5'd13;
    localparam logic [SLOT_W-1:0] T_P00 = 5'd14;
    localparam logic [SLOT_W-1:0] T_P01 = 5'd15;
    localparam logic [SLOT_W-1:0] T_P10 = 5'd16;
    localparam logic [SLOT_W-1:0] T_P11 = 5'd17;
    localparam logic [SLOT_W-1:0] T_Y0  = 5'd18;
    localparam logic [SLOT_W-1:0] T_Y1  = 5'd19;
    localparam logic [SLOT_W-1:0] T_S00 = 5'd20;
    localparam logic [SLOT_W-1:0] T_S11 = 5'd21;
    localparam logic [SLOT_W-1:0] T_DET = 5'd22;
    localparam logic [SLOT_W-1:0] T_K00 = 5'd23;
    localparam logic [SLOT_W-1:0] T_K01 = 5'd24;
    localparam logic [SLOT_W-1:0] T_K10 = 5'd25;
    localparam logic [SLOT_W-1:0] T_K11 = 5'd26;
    localparam logic [SLOT_W-1:0] NONE  = 5'd0;

    // outside operands for loads
    localparam logic [SLOT_W-1:0] EX_DT = 5'd0;
    localparam logic [SLOT_W-1:0] EX_ZP = 5'd1;
    localparam logic [SLOT_W-1:0] EX_ZV = 5'd2;
    localparam logic [SLOT_W-1:0] EX_QP = 5'd3;
    localparam logic [SLOT_W-1:0] EX_QV = 5'd4;
    localparam logic [SLOT_W-1:0] EX_RP = 5'd5;
    localparam logic [SLOT_W-1:0] EX_RV = 5'd6;

    localparam logic [PC_W-1:0] POS_PC = 7'd16;
    localparam logic [PC_W-1:0] VEL_PC = 7'd35;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_LDX,
        OP_FORK,
        OP_END
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] dst;
        logic [SLOT_W-1:0] a;
        logic [SLOT_W-1:0] b;
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_MUL,
        ST_MFIN,
        ST_DIV,
        ST_DFIN,
        ST_OUT
    } state_t;

    function automatic uop_t mk(op_t o, logic [SLOT_W-1:0] d, logic [SLOT_W-1:0] a,
                                logic [SLOT_W-1:0] b);
        uop_t u;
        u.op  = o;
        u.dst = d;
        u.a   = a;
        u.b   = b;
        return u;
    endfunction

    function automatic uop_t uop_at(logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // predict
            7'd0:  u = mk(OP_LDX, T_DT,  EX_DT, NONE);
            7'd1:  u = mk(OP_MUL, T_A,   T_DT,  S_VEL);
            7'd2:  u = mk(OP_ADD, T_X0,  S_POS, T_A);
            7'd3:  u = mk(OP_MUL, T_A,   T_DT,  S_VP);
            7'd4:  u = mk(OP_ADD, T_A,   S_PP,  T_A);
            7'd5:  u = mk(OP_MUL, T_B,   T_DT,  S_VV);
            7'd6:  u = mk(OP_ADD, T_P01, S_PV,  T_B);
            7'd7:  u = mk(OP_MUL, T_B,   T_DT,  T_P01);
            7'd8:  u = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd9:  u = mk(OP_LDX, T_Q,   EX_QP, NONE);
            7'd10: u = mk(OP_ADD, T_P00, T_A,   T_Q);
            7'd11: u = mk(OP_MUL, T_B,   T_DT,  S_VV);
            7'd12: u = mk(OP_ADD, T_P10, S_VP,  T_B);
            7'd13: u = mk(OP_LDX, T_Q,   EX_QV, NONE);
            7'd14: u = mk(OP_ADD, T_P11, S_VV,  T_Q);
            7'd15: u = mk(OP_FORK, NONE, NONE,  NONE);
            // position-only update
            7'd16: u = mk(OP_LDX, T_Q,   EX_ZP, NONE);
            7'd17: u = mk(OP_SUB, T_Y0,  T_Q,   T_X0);
            7'd18: u = mk(OP_LDX, T_Q,   EX_RP, NONE);
            7'd19: u = mk(OP_ADD, T_C,   T_P00, T_Q);
            7'd20: u = mk(OP_DIV, T_K00, T_P00, T_C);
            7'd21: u = mk(OP_DIV, T_K10, T_P10, T_C);
            7'd22: u = mk(OP_MUL, T_A,   T_K00, T_Y0);
            7'd23: u = mk(OP_ADD, S_POS, T_X0,  T_A);
            7'd24: u = mk(OP_MUL, T_A,   T_K10, T_Y0);
            7'd25: u = mk(OP_ADD, S_VEL, S_VEL, T_A);
            7'd26: u = mk(OP_MUL, T_A,   T_K00, T_P00);
            7'd27: u = mk(OP_SUB, S_PP,  T_P00, T_A);
            7'd28: u = mk(OP_MUL, T_A,   T_K00, T_P01);
            7'd29: u = mk(OP_SUB, S_PV,  T_P01, T_A);
            7'd30: u = mk(OP_MUL, T_A,   T_K10, T_P00);
            7'd31: u = mk(OP_SUB, S_VP,  T_P10, T_A);
            7'd32: u = mk(OP_MUL, T_A,   T_K10, T_P01);
            7'd33: u = mk(OP_SUB, S_VV,  T_P11, T_A);
            7'd34: u = mk(OP_END, NONE,  NONE,  NONE);
            // position plus velocity update
            7'd35: u = mk(OP_LDX, T_Q,   EX_RP, NONE);
            7'd36: u = mk(OP_ADD, T_S00, T_P00, T_Q);
            7'd37: u = mk(OP_LDX, T_Q,   EX_RV, NONE);
            7'd38: u = mk(OP_ADD, T_S11, T_P11, T_Q);
            7'd39: u = mk(OP_MUL, T_A,   T_S00, T_S11);
            7'd40: u = mk(OP_MUL, T_B,   T_P01, T_P10);
            7'd41: u = mk(OP_SUB, T_DET, T_A,   T_B);
            7'd42: u = mk(OP_MUL, T_A,   T_P00, T_S11);
            7'd43: u = mk(OP_MUL, T_B,   T_P01, T_P10);
            7'd44: u = mk(OP_SUB, T_C,   T_A,   T_B);
            7'd45: u = mk(OP_DIV, T_K00, T_C,   T_DET);
            7'd46: u = mk(OP_MUL, T_A,   T_P01, T_S00);
            7'd47: u = mk(OP_MUL, T_B,   T_P00, T_P01);
            7'd48: u = mk(OP_SUB, T_C,   T_A,   T_B);
            7'd49: u = mk(OP_DIV, T_K01, T_C,   T_DET);
            7'd50: u = mk(OP_MUL, T_A,   T_P10, T_S11);
            7'd51: u = mk(OP_MUL, T_B,   T_P11, T_P10);
            7'd52: u = mk(OP_SUB, T_C,   T_A,   T_B);
            7'd53: u = mk(OP_DIV, T_K10, T_C,   T_DET);
            7'd54: u = mk(OP_MUL, T_A,   T_P11, T_S00);
            7'd55: u = mk(OP_MUL, T_B,   T_P10, T_P01);
            7'd56: u = mk(OP_SUB, T_C,   T_A,   T_B);
            7'd57: u = mk(OP_DIV, T_K11, T_C,   T_DET);
            7'd58: u = mk(OP_LDX, T_Q,   EX_ZP, NONE);
            7'd59: u = mk(OP_SUB, T_Y0,  T_Q,   T_X0);
            7'd60: u = mk(OP_LDX, T_Q,   EX_ZV, NONE);
            7'd61: u = mk(OP_SUB, T_Y1,  T_Q,   S_VEL);
            7'd62: u = mk(OP_MUL, T_A,   T_K00, T_Y0);
            7'd63: u = mk(OP_MUL, T_B,   T_K01, T_Y1);
            7'd64: u = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd65: u = mk(OP_ADD, S_POS, T_X0,  T_A);
            7'd66: u = mk(OP_MUL, T_A,   T_K10, T_Y0);
            7'd67: u = mk(OP_MUL, T_B,   T_K11, T_Y1);
            7'd68: u = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd69: u = mk(OP_ADD, S_VEL, S_VEL, T_A);
            7'd70: u = mk(OP_MUL, T_A,   T_K00, T_P00);
            7'd71: u = mk(OP_MUL, T_B,   T_K01, T_P10);
            7'd72: u = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd73: u = mk(OP_SUB, S_PP,  T_P00, T_A);
            7'd74: u = mk(OP_MUL, T_A,   T_K00, T_P01);
            7'd75: u = mk(OP_MUL, T_B,   T_K01, T_P11);
            7'd76: u = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd77: u = mk(OP_SUB, S_PV,  T_P01, T_A);
            7'd78: u = mk(OP_MUL, T_A,   T_K10, T_P00);
            7'd79: u = mk(OP_MUL, T_B,   T_K11, T_P10);
            7'd80: u = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd81: u = mk(OP_SUB, S_VP,  T_P10, T_A);
            7'd82: u = mk(OP_MUL, T_A,   T_K10, T_P01);
            7'd83: u = mk(OP_MUL, T_B,   T_K11, T_P11);
            7'd84: u = mk(OP_ADD, T_A,   T_A,   T_B);
            7'd85: u = mk(OP_SUB, S_VV,  T_P11, T_A);
            default: u = mk(OP_END, NONE, NONE, NONE);
        endcase
        return u;
    endfunction

    function automatic logic [VW-1:0] mag48(logic [VW-1:0] v);
        return v[VW-1] ? (~v + VW'(1)) : v;
    endfunction

    // magnitude plus sign back to a saturated two's complement value
    function automatic logic [VW-1:0] sat_mag(logic [PROD_W-1:0] m, logic neg);
        logic [VW-1:0] r;
        if (neg)
        begin
            if (m > PROD_W'(VMIN))
                r = VMIN;
            else
                r = ~m[VW-1:0] + VW'(1);
        end
        else
        begin
            if (m > PROD_W'(VMAX))
                r = VMAX;
            else
                r = m[VW-1:0];
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] sat_sum(logic [VW:0] s);
        logic [VW-1:0] r;
        if (s[VW] != s[VW-1])
            r = s[VW] ? VMIN : VMAX;
        else
            r = s[VW-1:0];
        return r;
    endfunction

    function automatic logic [VW-1:0] reset_val(logic [SLOT_W-1:0] slot);
        return (slot == S_PP || slot == S_VV) ? ONE_VAL : '0;
    endfunction

endpackage

// ----- rtl/core/two_state_kalman_filter.sv -----
// bank of per-joint two-state constant-velocity kalman filters
// input stream: one word per measurement (joint, elapsed, meas_pos, meas_vel);
// output stream: one word per input (joint_out, filtered_pos, filtered_vel).
// the block takes one word at a time: s_axis_tready is high only while idle.
// each word runs a micro-program on one shared unit: saturating add/sub, a
// 48x48 multiply as four 24x24 partial products, and a restoring divider at
// one quotient bit per cycle. ops read two operands from the scratch/state
// ram, so each op also passes through a fetch state.
// a joint index beyond the bank answers zeros in the cycle after accept.
// the result word holds on m_axis until m_axis_tready; no new word is taken
// until it is delivered, and the block is ready again in the following cycle.
// reset loads the default noise and step registers and marks every joint as
// fresh, so it reads zero estimates and identity covariance; no clearing pass.
// configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle; the block itself does not enforce this.
`include "two_state_kalman_filter_defines.svh"

module two_state_kalman_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // joint[2:0], elapsed[34:3], meas_pos[82:35], meas_vel[130:83], zero fill
    input  logic [135:0]                    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // joint_out[2:0], filtered_pos[50:3], filtered_vel[98:51], zero fill
    output logic [103:0]                    m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [tskf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tskf_pkg::NW-1:0]         cfg_data
);

    localparam int VW   = tskf_pkg::VW;
    localparam int AW   = $clog2(tskf_pkg::RAM_DEPTH);
    localparam int HW   = tskf_pkg::HALF_W;
    localparam int PW   = tskf_pkg::PROD_W;
    localparam int DW   = tskf_pkg::DIV_W;
    localparam int DCW  = tskf_pkg::DIV_CW;

    tskf_pkg::state_t state_reg, state_next;

    // configuration
    logic [tskf_pkg::NW-1:0]     qp_reg, qv_reg, rp_reg, rv_reg;
    logic                        usevel_reg;
    logic [tskf_pkg::STEP_W-1:0] dstep_reg, mstep_reg;

    // captured input word
    logic [tskf_pkg::JOINT_W-1:0] jnt_reg, jnt_next;
    logic [tskf_pkg::STEP_W-1:0]  elap_reg, elap_next;
    logic [VW-1:0]                zp_reg, zp_next, zv_reg, zv_next;

    logic [tskf_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [tskf_pkg::JOINTS-1:0] valid_reg, valid_next;
    logic [VW-1:0] pos_out_reg, pos_out_next, vel_out_reg, vel_out_next;

    // multiplier and divider state
    logic [1:0]    mul_cnt_reg, mul_cnt_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [VW:0]   rem_reg, rem_next;
    logic [49:0]   quo_reg, quo_next;
    logic          big_reg, big_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;

    tskf_pkg::uop_t cur;
    logic [AW-1:0]  addr_a, addr_b, addr_d;
    logic [VW-1:0]  rdata_a, rdata_b, opa, opb, ma, mb, ext, res, dt;
    logic           neg, ram_we, in_range;
    logic [tskf_pkg::STEP_W-1:0] step_sel;
    logic [HW-1:0]  pa, pb;
    logic [PW-1:0]  pp_sh, rnd;
    logic [VW:0]    rem_sh, rem_sub;

    function automatic logic [AW-1:0] slot_addr(logic [tskf_pkg::SLOT_W-1:0] slot,
                                                logic [tskf_pkg::JOINT_W-1:0] j);
        logic [AW-1:0] a;
        if (slot < 5'd8)
            a = AW'({j, slot[2:0]});
        else
            a = AW'(tskf_pkg::JOINTS * 8) + AW'(slot);
        return a;
    endfunction

    assign cur      = tskf_pkg::uop_at(pc_reg);
    assign addr_a   = slot_addr(cur.a, jnt_reg);
    assign addr_b   = slot_addr(cur.b, jnt_reg);
    assign addr_d   = slot_addr(cur.dst, jnt_reg);
    assign in_range = {1'b0, s_axis_tdata[2:0]} < 4'(tskf_pkg::JOINTS);

    tskf_ram #(
        .WIDTH (VW),
        .DEPTH (tskf_pkg::RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (addr_d),
        .wdata   (res),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // state of a joint never written reads as its reset value
    always_comb
    begin
        opa = (cur.a < 5'd8 && !valid_reg[jnt_reg]) ? tskf_pkg::reset_val(cur.a) : rdata_a;
        opb = (cur.b < 5'd8 && !valid_reg[jnt_reg]) ? tskf_pkg::reset_val(cur.b) : rdata_b;
        ma  = tskf_pkg::mag48(opa);
        mb  = tskf_pkg::mag48(opb);
        neg = opa[VW-1] ^ opb[VW-1];
    end

    // step clamp and conversion to the value format
    always_comb
    begin
        if (elap_reg == '0 || elap_reg > mstep_reg)
            step_sel = dstep_reg;
        else
            step_sel = elap_reg;
        dt = VW'(((VW'(step_sel) + VW'((1 << tskf_pkg::DT_SHR) >> 1)) >> tskf_pkg::DT_SHR)
                 << tskf_pkg::DT_SHL);
    end

    always_comb
    begin
        case (cur.a)
            tskf_pkg::EX_DT: ext = dt;
            tskf_pkg::EX_ZP: ext = zp_reg;
            tskf_pkg::EX_ZV: ext = zv_reg;
            tskf_pkg::EX_QP: ext = VW'(qp_reg);
            tskf_pkg::EX_QV: ext = VW'(qv_reg);
            tskf_pkg::EX_RP: ext = VW'(rp_reg);
            tskf_pkg::EX_RV: ext = VW'(rv_reg);
            default:         ext = '0;
        endcase
    end

    // one partial product per cycle
    always_comb
    begin
        pa = mul_cnt_reg[1] ? ma[VW-1:HW] : ma[HW-1:0];
        pb = mul_cnt_reg[0] ? mb[VW-1:HW] : mb[HW-1:0];
        pp_sh = PW'(pa * pb) << (HW * (32'(mul_cnt_reg[1]) + 32'(mul_cnt_reg[0])));
        rnd   = (acc_reg + (PW'(1) << (tskf_pkg::FRAC_BITS - 1))) >> tskf_pkg::FRAC_BITS;
    end

    // one restoring divide step
    always_comb
    begin
        rem_sh  = {rem_reg[VW-1:0], dvd_reg[DW-1]};
        rem_sub = rem_sh - {1'b0, mb};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tskf_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = in_range ? tskf_pkg::ST_FETCH : tskf_pkg::ST_OUT;
            end
            tskf_pkg::ST_FETCH:
                state_next = tskf_pkg::ST_EXEC;
            tskf_pkg::ST_EXEC:
            begin
                unique case (cur.op)
                    tskf_pkg::OP_MUL: state_next = tskf_pkg::ST_MUL;
                    tskf_pkg::OP_DIV: state_next = tskf_pkg::ST_DIV;
                    tskf_pkg::OP_END: state_next = tskf_pkg::ST_OUT;
                    default:          state_next = tskf_pkg::ST_FETCH;
                endcase
            end
            tskf_pkg::ST_MUL:
            begin
                if (mul_cnt_reg == 2'd3)
                    state_next = tskf_pkg::ST_MFIN;
            end
            tskf_pkg::ST_DIV:
            begin
                if (div_cnt_reg == DCW'(DW - 1))
                    state_next = tskf_pkg::ST_DFIN;
            end
            tskf_pkg::ST_MFIN,
            tskf_pkg::ST_DFIN:
                state_next = tskf_pkg::ST_FETCH;
            tskf_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = tskf_pkg::ST_IDLE;
            end
            default:
                state_next = tskf_pkg::ST_IDLE;
        endcase
    end

    // datapath and sequencer outputs
    always_comb
    begin
        jnt_next     = jnt_reg;
        elap_next    = elap_reg;
        zp_next      = zp_reg;
        zv_next      = zv_reg;
        pc_next      = pc_reg;
        valid_next   = valid_reg;
        pos_out_next = pos_out_reg;
        vel_out_next = vel_out_reg;
        mul_cnt_next = mul_cnt_reg;
        acc_next     = acc_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        big_next     = big_reg;
        div_cnt_next = div_cnt_reg;
        ram_we       = 1'b0;
        res          = '0;
        unique case (state_reg)
            tskf_pkg::ST_IDLE:
            begin
                jnt_next     = s_axis_tdata[2:0];
                elap_next    = s_axis_tdata[34:3];
                zp_next      = s_axis_tdata[82:35];
                zv_next      = s_axis_tdata[130:83];
                pc_next      = '0;
                pos_out_next = '0;
                vel_out_next = '0;
            end
            tskf_pkg::ST_EXEC:
            begin
                pc_next = pc_reg + tskf_pkg::PC_W'(1);
                case (cur.op)
                    tskf_pkg::OP_ADD:
                    begin
                        res    = tskf_pkg::sat_sum({opa[VW-1], opa} + {opb[VW-1], opb});
                        ram_we = 1'b1;
                    end
                    tskf_pkg::OP_SUB:
                    begin
                        res    = tskf_pkg::sat_sum({opa[VW-1], opa} - {opb[VW-1], opb});
                        ram_we = 1'b1;
                    end
                    tskf_pkg::OP_LDX:
                    begin
                        res    = ext;
                        ram_we = 1'b1;
                    end
                    tskf_pkg::OP_MUL:
                    begin
                        pc_next      = pc_reg;
                        acc_next     = '0;
                        mul_cnt_next = '0;
                    end
                    tskf_pkg::OP_DIV:
                    begin
                        pc_next      = pc_reg;
                        dvd_next     = (DW'(ma) << tskf_pkg::FRAC_BITS) + DW'(mb >> 1);
                        rem_next     = '0;
                        quo_next     = '0;
                        big_next     = 1'b0;
                        div_cnt_next = '0;
                    end
                    tskf_pkg::OP_FORK:
                        pc_next = usevel_reg ? tskf_pkg::VEL_PC : tskf_pkg::POS_PC;
                    tskf_pkg::OP_END:
                        valid_next[jnt_reg] = 1'b1;
                    default:
                        pc_next = pc_reg;
                endcase
            end
            tskf_pkg::ST_MUL:
            begin
                acc_next     = acc_reg + pp_sh;
                mul_cnt_next = mul_cnt_reg + 2'd1;
            end
            tskf_pkg::ST_MFIN:
            begin
                res          = tskf_pkg::sat_mag(rnd, neg);
                ram_we       = 1'b1;
                mul_cnt_next = '0;
                pc_next      = pc_reg + tskf_pkg::PC_W'(1);
            end
            tskf_pkg::ST_DIV:
            begin
                dvd_next = dvd_reg << 1;
                if (!rem_sub[VW])
                    rem_next = rem_sub;
                else
                    rem_next = rem_sh;
                // quotient beyond 50 bits only ever saturates
                big_next     = big_reg | quo_reg[49];
                quo_next     = {quo_reg[48:0], ~rem_sub[VW]};
                div_cnt_next = div_cnt_reg + DCW'(1);
            end
            tskf_pkg::ST_DFIN:
            begin
                if (mb == '0)
                    res = '0;
                else if (big_reg)
                    res = tskf_pkg::sat_mag({PW{1'b1}}, neg);
                else
                    res = tskf_pkg::sat_mag(PW'(quo_reg), neg);
                ram_we  = 1'b1;
                pc_next = pc_reg + tskf_pkg::PC_W'(1);
            end
            default:
            begin
            end
        endcase
        // estimate written back to the state is also the result word
        if (ram_we && cur.dst == tskf_pkg::S_POS)
            pos_out_next = res;
        if (ram_we && cur.dst == tskf_pkg::S_VEL)
            vel_out_next = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tskf_pkg::ST_IDLE;
            pc_reg      <= '0;
            valid_reg   <= '0;
            mul_cnt_reg <= '0;
            div_cnt_reg <= '0;
            qp_reg      <= tskf_pkg::RST_QP;
            qv_reg      <= tskf_pkg::RST_QV;
            rp_reg      <= tskf_pkg::RST_RP;
            rv_reg      <= tskf_pkg::RST_RV;
            usevel_reg  <= 1'b0;
            dstep_reg   <= tskf_pkg::RST_DSTEP;
            mstep_reg   <= tskf_pkg::RST_MSTEP;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            valid_reg   <= valid_next;
            mul_cnt_reg <= mul_cnt_next;
            div_cnt_reg <= div_cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tskf_pkg::REG_QP:     qp_reg     <= cfg_data;
                    tskf_pkg::REG_QV:     qv_reg     <= cfg_data;
                    tskf_pkg::REG_RP:     rp_reg     <= cfg_data;
                    tskf_pkg::REG_RV:     rv_reg     <= cfg_data;
                    tskf_pkg::REG_USEVEL: usevel_reg <= cfg_data[0];
                    tskf_pkg::REG_DSTEP:  dstep_reg  <= cfg_data[tskf_pkg::STEP_W-1:0];
                    tskf_pkg::REG_MSTEP:  mstep_reg  <= cfg_data[tskf_pkg::STEP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        jnt_reg     <= jnt_next;
        elap_reg    <= elap_next;
        zp_reg      <= zp_next;
        zv_reg      <= zv_next;
        pos_out_reg <= pos_out_next;
        vel_out_reg <= vel_out_next;
        acc_reg     <= acc_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        big_reg     <= big_next;
    end

    assign s_axis_tready = (state_reg == tskf_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == tskf_pkg::ST_OUT);
    assign m_axis_tdata  = {5'b0, vel_out_reg, pos_out_reg, jnt_reg};

    `TSKF_ASSERT_NOW(a_ready_excl, s_axis_tready, !m_axis_tvalid, "ready while result pending")
    `TSKF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted word did not start work")
    `TSKF_ASSERT_NOW(a_div_done, state_reg == tskf_pkg::ST_DFIN, div_cnt_reg == DCW'(DW), "divider finished early")

endmodule

// ----- rtl/core/tskf_ram.sv -----
// generic single-write, dual-read ram with registered read data
module tskf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
